// File: rtl/bst_preorder_verifier_core_assert.svh
// Assertion macros for the BST preorder verifier checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef BST_PREORDER_VERIFIER_CORE_ASSERT_SVH
`define BST_PREORDER_VERIFIER_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define BPV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpv assertion failed");

// Clocked check that also holds during reset.
`define BPV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bpv assertion failed");

`endif

// File: rtl/bpv_pkg.sv
// Package for the BST preorder verifier: widths, constants, sequencer states.
// No dependencies.
package bpv_pkg;

    localparam int unsigned KEY_W           = 32;
    localparam int unsigned STACK_DEPTH_DEF = 64;

    localparam logic signed [KEY_W-1:0] INT_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic {
        ST_IDLE,
        ST_CMP
    } t_state;

endpackage

// File: rtl/bpv_if.sv
// Valid/ready channel interfaces for key beats and verdict beats.
// Depends on bpv_pkg.
interface bpv_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bpv_pkg::KEY_W-1:0]     value;
    logic                                 last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface bpv_out_if;
    logic valid;
    logic ready;
    logic is_preorder;
    logic overflow;

    modport source (output valid, output is_preorder, output overflow, input ready);
    modport sink   (input valid, input is_preorder, input overflow, output ready);
endinterface

// File: rtl/bpv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpv_cmp_unit.sv
// Shared signed less-than comparator used for bound checks and stack pops.
// Depends on bpv_pkg.
module bpv_cmp_unit (
    input  logic signed [bpv_pkg::KEY_W-1:0] i_a,
    input  logic signed [bpv_pkg::KEY_W-1:0] i_b,
    output logic                             o_lt
);

    assign o_lt = (i_a < i_b);

endmodule

// File: rtl/bst_preorder_verifier_core.sv
// Channel    | dir | payload               | handshake
// i_in       | in  | value[31:0], last     | valid/ready, beat on both high
// o_out      | out | is_preorder, overflow | valid/ready, beat on both high
//
// A key is accepted, then the stack is popped while its top is below the key,
// then the key is pushed; each key is popped at most once. These steps run in
// turn on the shared comparator and the single stack RAM read port.
// Keys after a failure, or below the bound, are handled in the accept step alone.
// Synchronous active-low reset clears the control state; no clearing pass.
// A stalled verdict holds i_in.ready low until it is taken.
// Depends on bpv_pkg, bpv_if, bpv_ram, bpv_cmp_unit.
module bst_preorder_verifier_core #(
    parameter int unsigned STACK_DEPTH = bpv_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpv_in_if.sink        i_in,
    bpv_out_if.source     o_out
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    bpv_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic signed [bpv_pkg::KEY_W-1:0] r_bound, n_bound;
    logic signed [bpv_pkg::KEY_W-1:0] r_top, n_top;
    logic signed [bpv_pkg::KEY_W-1:0] r_key, n_key;
    logic            r_last, n_last;
    logic            r_failed, n_failed;
    logic            r_ovf, n_ovf;
    logic            r_sel, n_sel;
    logic            r_out_valid, n_out_valid;
    logic            r_out_pre, n_out_pre;
    logic            r_out_ovf, n_out_ovf;

    logic signed [bpv_pkg::KEY_W-1:0] top;
    logic signed [bpv_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic [bpv_pkg::KEY_W-1:0]        ram_rdata;
    logic            lt;
    logic            in_ready, accept;
    logic            ram_we, ram_re;
    logic [CW-1:0]   rd_cnt;

    bpv_cmp_unit u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (lt)
    );

    bpv_ram #(
        .WIDTH (bpv_pkg::KEY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (rd_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        top      = r_sel ? $signed(ram_rdata) : r_top;
        cmp_a    = (r_state == bpv_pkg::ST_IDLE) ? i_in.value : top;
        cmp_b    = (r_state == bpv_pkg::ST_IDLE) ? r_bound : r_key;
        in_ready = (r_state == bpv_pkg::ST_IDLE) && (!r_out_valid || o_out.ready);
        accept   = i_in.valid && in_ready;
        rd_cnt   = r_count - TWO_C;

        n_state     = r_state;
        n_count     = r_count;
        n_bound     = r_bound;
        n_top       = r_top;
        n_key       = r_key;
        n_last      = r_last;
        n_failed    = r_failed;
        n_ovf       = r_ovf;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pre   = r_out_pre;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (r_state)
            bpv_pkg::ST_IDLE: begin
                if (accept) begin
                    n_key  = i_in.value;
                    n_last = i_in.last;
                    if (r_failed || lt) begin
                        if (i_in.last) begin
                            n_out_valid = 1'b1;
                            n_out_pre   = 1'b0;
                            n_out_ovf   = r_ovf;
                            n_count     = '0;
                            n_bound     = bpv_pkg::INT_MIN;
                            n_failed    = 1'b0;
                            n_ovf       = 1'b0;
                            n_sel       = 1'b0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else begin
                        n_state = bpv_pkg::ST_CMP;
                    end
                end
            end
            bpv_pkg::ST_CMP: begin
                if ((r_count != '0) && lt) begin
                    n_bound = top;
                    n_count = r_count - ONE_C;
                    if (r_count >= TWO_C) begin
                        ram_re = 1'b1;
                        n_sel  = 1'b1;
                    end
                end else begin
                    if (r_count == DEPTH_C) begin
                        n_ovf = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + ONE_C;
                        n_top   = r_key;
                        n_sel   = 1'b0;
                    end
                    n_state = bpv_pkg::ST_IDLE;
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_pre   = 1'b1;
                        n_out_ovf   = r_ovf || (r_count == DEPTH_C);
                        n_count     = '0;
                        n_bound     = bpv_pkg::INT_MIN;
                        n_failed    = 1'b0;
                        n_ovf       = 1'b0;
                        n_sel       = 1'b0;
                    end
                end
            end
            default: begin
                n_state = bpv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpv_pkg::ST_IDLE;
            r_count     <= '0;
            r_bound     <= bpv_pkg::INT_MIN;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bound     <= n_bound;
            r_failed    <= n_failed;
            r_ovf       <= n_ovf;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_key     <= n_key;
        r_last    <= n_last;
        r_out_pre <= n_out_pre;
        r_out_ovf <= n_out_ovf;
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.is_preorder = r_out_pre;
    assign o_out.overflow    = r_out_ovf;

endmodule

// File: rtl/bpv_checker.sv
// Port-level checks for the BST preorder verifier, bound to bst_preorder_verifier_core.
// Depends on bst_preorder_verifier_core_assert.svh and bst_preorder_verifier_core.
`include "bst_preorder_verifier_core_assert.svh"

module bpv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_pre,
    input logic i_out_ovf
);

    // stalled verdict holds
    `BPV_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pre) && $stable(i_out_ovf)))
    // no key taken while a verdict is stuck
    `BPV_ASSERT(a_no_take_on_stall, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |-> !i_in_ready)
    // reset empties the output
    `BPV_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind bst_preorder_verifier_core bpv_checker u_bpv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pre   (o_out.is_preorder),
    .i_out_ovf   (o_out.overflow)
);
